### hdl/npvp_pkg.sv
`default_nettype none
package npvp_pkg;

	localparam int NUM_W  = 41;
	localparam int UW_W   = 40;
	localparam int QBITS  = 17;
	localparam int CNT_W  = 5;
	localparam int DIV_W  = 59;
	localparam int DIST_W = 37;

	typedef enum logic [3:0] {
		CFG_CLIP_X   = 4'd0,
		CFG_CLIP_Y   = 4'd1,
		CFG_CLIP_W   = 4'd2,
		CFG_VP_W     = 4'd3,
		CFG_VP_H     = 4'd4,
		CFG_TARGET_X = 4'd5,
		CFG_TARGET_Y = 4'd6,
		CFG_RADIUS   = 4'd7
	} cfg_index_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_DIV,
		B_DIST,
		B_UPD
	} back_state_t;

	typedef struct packed {
		logic              keep;
		logic              last;
		logic [NUM_W-1:0]  nx;
		logic [NUM_W-1:0]  ny;
		logic [UW_W-1:0]   uw;
	} proj_t;

	typedef struct packed {
		logic [12:0] width;
		logic [12:0] height;
		logic [15:0] tx;
		logic [15:0] ty;
		logic [15:0] radius;
	} cfg_back_t;

endpackage
`default_nettype wire

### hdl/npvp_front.sv
`default_nettype none
module npvp_front #(
	parameter int COORD_BITS = 16,
	parameter int COEFF_FRAC_BITS = 12
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [COORD_BITS-1:0]   vx,
	input  wire logic [COORD_BITS-1:0]   vy,
	input  wire logic [COORD_BITS-1:0]   vz,
	input  wire logic                    last,
	input  wire logic [63:0]             row_x,
	input  wire logic [63:0]             row_y,
	input  wire logic [63:0]             row_w,
	output logic                         push_valid,
	input  wire logic                    push_ready,
	output npvp_pkg::proj_t              push_proj,
	output logic [3*COORD_BITS-1:0]      push_pos
);
	import npvp_pkg::*;

	localparam int PW = 16 + COORD_BITS;
	localparam int CW = PW + 2;
	localparam int VF = COORD_BITS / 2;
	localparam int CF = VF + COEFF_FRAC_BITS;
	localparam longint EPS = (64'sd1 <<< CF) / 10000;
	localparam int XW = (CW > NUM_W) ? CW : NUM_W;
	localparam int NSH = XW - UW_W;

	logic                   v_s1, v_s2, rdy_s1, rdy_s2;
	logic signed [PW-1:0]   prod_s1 [3][4];
	logic [3*COORD_BITS-1:0] pos_s1, pos_s2;
	logic                   last_s1, last_s2;
	logic signed [CW-1:0]   sum_s2 [3];
	logic signed [PW-1:0]   opnd [4];
	logic [63:0]            rows [3];

	assign rows[0] = row_x;
	assign rows[1] = row_y;
	assign rows[2] = row_w;
	assign opnd[0] = PW'($signed(vx));
	assign opnd[1] = PW'($signed(vy));
	assign opnd[2] = PW'($signed(vz));
	assign opnd[3] = PW'(1) <<< VF;

	assign rdy_s2   = !v_s2 || push_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 4; k++)
					prod_s1[r][k] <= PW'($signed(rows[r][16*k +: 16]) * opnd[k]);
			pos_s1  <= {vz, vy, vx};
			last_s1 <= last;
		end
		if (rdy_s2 && v_s1) begin
			for (int r = 0; r < 3; r++)
				sum_s2[r] <= CW'(prod_s1[r][0]) + CW'(prod_s1[r][1])
					+ CW'(prod_s1[r][2]) + CW'(prod_s1[r][3]);
			pos_s2  <= pos_s1;
			last_s2 <= last_s1;
		end
	end

	logic signed [CW:0] cx, cy, w, nxs, nys;
	logic [XW-1:0]      nx_e, ny_e, uw_e;
	logic [$clog2(NSH+1)-1:0] sh;

	always_comb begin
		cx  = (CW+1)'(sum_s2[0]);
		cy  = (CW+1)'(sum_s2[1]);
		w   = (CW+1)'(sum_s2[2]);
		nxs = cx + w;
		nys = w - cy;
		nx_e = XW'(unsigned'(nxs[CW-1:0]));
		ny_e = XW'(unsigned'(nys[CW-1:0]));
		uw_e = XW'(unsigned'(w[CW-1:0]));
		sh = '0;
		for (int s = NSH; s >= 0; s--)
			if ((uw_e >> s) < (XW'(1) << UW_W)) sh = ($clog2(NSH+1))'(s);
		push_proj.keep = (w > (CW+1)'(EPS)) && (cx >= -w) && (cx <= w)
			&& (cy >= -w) && (cy <= w);
		push_proj.last = last_s2;
		push_proj.nx   = NUM_W'(nx_e >> sh);
		push_proj.ny   = NUM_W'(ny_e >> sh);
		push_proj.uw   = UW_W'(uw_e >> sh);
		push_pos   = pos_s2;
		push_valid = v_s2;
	end

endmodule
`default_nettype wire

### hdl/npvp_fifo.sv
`default_nettype none
module npvp_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

### hdl/npvp_back.sv
`default_nettype none
module npvp_back #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    pop_valid,
	output logic                         pop_ready,
	input  wire npvp_pkg::proj_t         pop_proj,
	input  wire logic [3*COORD_BITS-1:0] pop_pos,
	input  wire npvp_pkg::cfg_back_t     cfg,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         found,
	output logic [COORD_BITS-1:0]        best_x,
	output logic [COORD_BITS-1:0]        best_y,
	output logic [COORD_BITS-1:0]        best_z
);
	import npvp_pkg::*;

	back_state_t             state_q, state_d;
	proj_t                   cur_q;
	logic [3*COORD_BITS-1:0] pos_q, bpos_q, out_pos_q;
	logic [DIV_W-1:0]        remx_q, remy_q, dsh_q;
	logic [QBITS-1:0]        qx_q, qy_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DIST_W-1:0]       dist_q;
	logic [31:0]             rsq_q;
	logic [33:0]             best_q;
	logic                    found_q, set_open_q, out_valid_q, out_found_q;
	logic                    slot_free;

	logic signed [17:0]      dx, dy;
	logic signed [35:0]      sqx, sqy;
	logic [33:0]             cur_best;
	logic                    better, new_found;
	logic [3*COORD_BITS-1:0] new_pos;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		dx = $signed({1'b0, qx_q}) - $signed({2'b0, cfg.tx});
		dy = $signed({1'b0, qy_q}) - $signed({2'b0, cfg.ty});
		sqx = 36'(dx * dx);
		sqy = 36'(dy * dy);
		cur_best  = set_open_q ? best_q : {2'b0, rsq_q};
		better    = cur_q.keep && (dist_q < DIST_W'(cur_best));
		new_found = better || (set_open_q && found_q);
		new_pos   = better ? pos_q : (set_open_q ? bpos_q : '0);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (pop_valid) state_d = B_MUL;
			B_MUL:  state_d = cur_q.keep ? B_DIV : B_UPD;
			B_DIV:  if (cnt_q == '0) state_d = B_DIST;
			B_DIST: state_d = B_UPD;
			B_UPD:  if (!cur_q.last || slot_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = (state_q == B_IDLE);
		out_valid = out_valid_q;
		found     = out_found_q;
		best_x    = out_pos_q[0 +: COORD_BITS];
		best_y    = out_pos_q[COORD_BITS +: COORD_BITS];
		best_z    = out_pos_q[2*COORD_BITS +: COORD_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			set_open_q  <= 1'b0;
			found_q     <= 1'b0;
			best_q      <= '0;
			bpos_q      <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == B_UPD) begin
				if (!cur_q.last) begin
					set_open_q <= 1'b1;
					found_q    <= new_found;
					bpos_q     <= new_pos;
					if (better) best_q <= dist_q[33:0];
					else        best_q <= cur_best;
				end else if (slot_free) begin
					out_valid_q <= 1'b1;
					set_open_q  <= 1'b0;
					found_q     <= 1'b0;
					best_q      <= '0;
					bpos_q      <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					cur_q <= pop_proj;
					pos_q <= pop_pos;
				end
			end
			B_MUL: begin
				remx_q <= ((DIV_W'(cur_q.nx) * DIV_W'(cfg.width)) << 4) + DIV_W'(cur_q.uw);
				remy_q <= ((DIV_W'(cur_q.ny) * DIV_W'(cfg.height)) << 4) + DIV_W'(cur_q.uw);
				dsh_q  <= DIV_W'({cur_q.uw, 1'b0}) << (QBITS - 1);
				cnt_q  <= CNT_W'(QBITS - 1);
				rsq_q  <= 32'(cfg.radius) * 32'(cfg.radius);
			end
			B_DIV: begin
				if (remx_q >= dsh_q) begin
					remx_q <= remx_q - dsh_q;
					qx_q   <= {qx_q[QBITS-2:0], 1'b1};
				end else begin
					qx_q   <= {qx_q[QBITS-2:0], 1'b0};
				end
				if (remy_q >= dsh_q) begin
					remy_q <= remy_q - dsh_q;
					qy_q   <= {qy_q[QBITS-2:0], 1'b1};
				end else begin
					qy_q   <= {qy_q[QBITS-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			B_DIST: begin
				dist_q <= DIST_W'(unsigned'(sqx)) + DIST_W'(unsigned'(sqy));
			end
			B_UPD: begin
				if (cur_q.last && slot_free) begin
					out_found_q <= new_found;
					out_pos_q   <= new_found ? new_pos : '0;
				end
			end
			default: begin
			end
		endcase
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> cnt_q <= CNT_W'(QBITS - 1))
		else $error("divider step count out of range");
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == B_UPD && cur_q.last))
		else $error("result raised outside a last-vertex update");
	a_closed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> !set_open_q && !found_q)
		else $error("search state not cleared after a result");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != B_IDLE |-> !pop_ready)
		else $error("queue popped while a vertex is in work");

endmodule
`default_nettype wire

### hdl/nearest_projected_vertex_pick.sv
// A result beat is registered from the last vertex's update. A vertex passing the clip
// test runs the two 17-step restoring dividers that share one sequencer in the back
// end; a skipped vertex bypasses them. The back end takes a new vertex only when idle.
// The front end and a two-entry queue run ahead by up to four vertices.
// Reset (arst_n low) clears handshakes, the search state and the registers to defaults.
`default_nettype none
module nearest_projected_vertex_pick #(
	parameter int COORD_BITS = 16,
	parameter int COEFF_FRAC_BITS = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [COORD_BITS-1:0] vertex_x,
	input  wire logic [COORD_BITS-1:0] vertex_y,
	input  wire logic [COORD_BITS-1:0] vertex_z,
	input  wire logic                  last_vertex,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       found,
	output logic [COORD_BITS-1:0]      best_x,
	output logic [COORD_BITS-1:0]      best_y,
	output logic [COORD_BITS-1:0]      best_z,
	input  wire logic                  cfg_we,
	input  wire logic [3:0]            cfg_index,
	input  wire logic [63:0]           cfg_data
);
	import npvp_pkg::*;

	localparam int FW = $bits(proj_t) + 3 * COORD_BITS;

	logic [63:0]             row_x_q, row_y_q, row_w_q;
	cfg_back_t               cfg_q;
	logic                    f_valid, f_ready, b_valid, b_ready;
	proj_t                   f_proj, b_proj;
	logic [3*COORD_BITS-1:0] f_pos, b_pos;
	logic [FW-1:0]           b_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q       <= '0;
			row_y_q       <= '0;
			row_w_q       <= '0;
			cfg_q.width   <= 13'd1;
			cfg_q.height  <= 13'd1;
			cfg_q.tx      <= '0;
			cfg_q.ty      <= '0;
			cfg_q.radius  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLIP_X:   row_x_q      <= cfg_data;
				CFG_CLIP_Y:   row_y_q      <= cfg_data;
				CFG_CLIP_W:   row_w_q      <= cfg_data;
				CFG_VP_W:     cfg_q.width  <= cfg_data[12:0];
				CFG_VP_H:     cfg_q.height <= cfg_data[12:0];
				CFG_TARGET_X: cfg_q.tx     <= cfg_data[15:0];
				CFG_TARGET_Y: cfg_q.ty     <= cfg_data[15:0];
				CFG_RADIUS:   cfg_q.radius <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	npvp_front #(
		.COORD_BITS(COORD_BITS),
		.COEFF_FRAC_BITS(COEFF_FRAC_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.vx(vertex_x), .vy(vertex_y), .vz(vertex_z), .last(last_vertex),
		.row_x(row_x_q), .row_y(row_y_q), .row_w(row_w_q),
		.push_valid(f_valid), .push_ready(f_ready),
		.push_proj(f_proj), .push_pos(f_pos)
	);

	npvp_fifo #(.WIDTH(FW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_ready(f_ready), .push_data({f_proj, f_pos}),
		.pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data)
	);

	assign b_proj = b_data[FW-1 -: $bits(proj_t)];
	assign b_pos  = b_data[3*COORD_BITS-1:0];

	npvp_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(b_valid), .pop_ready(b_ready),
		.pop_proj(b_proj), .pop_pos(b_pos), .cfg(cfg_q),
		.out_valid(out_valid), .out_ready(out_ready), .found(found),
		.best_x(best_x), .best_y(best_y), .best_z(best_z)
	);

endmodule
`default_nettype wire

### test/npvp_checker.sv
module npvp_checker
	import npvp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] vertex_x,
	input  logic [15:0] vertex_y,
	input  logic [15:0] vertex_z,
	input  logic        last_vertex,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        found,
	input  logic [15:0] best_x,
	input  logic [15:0] best_y,
	input  logic [15:0] best_z,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic        hit;
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] pz;
	} pick_t;

	localparam longint W_EPS = (64'sd1 <<< 20) / 10000;
	localparam longint W_CAP = 64'sd1 <<< 40;

	pick_t       expected_picks[$];
	logic [63:0] row_x, row_y, row_w;
	logic [12:0] vp_w, vp_h;
	logic [15:0] tgt_x, tgt_y, radius;
	longint      nearest_sq;
	logic [15:0] near_x, near_y, near_z;
	logic        near_hit;
	logic        in_set;

	function automatic longint project_row(logic [63:0] row, longint x, longint y, longint z);
		return longint'(signed'(row[15:0])) * x + longint'(signed'(row[31:16])) * y +
			longint'(signed'(row[47:32])) * z + longint'(signed'(row[63:48])) * 256;
	endfunction

	function automatic longint to_pixel(longint num, longint w, logic [12:0] size);
		return (num * longint'(size) * 16 + w) / (2 * w);
	endfunction

	function automatic void track_vertex(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
			logic fin);
		longint x, y, z, cx, cy, w, nx, ny, dx, dy, dsq;
		pick_t  res;
		x = longint'(signed'(vx));
		y = longint'(signed'(vy));
		z = longint'(signed'(vz));
		if (!in_set) begin
			nearest_sq = longint'(radius) * longint'(radius);
			near_hit = 1'b0;
			near_x = '0;
			near_y = '0;
			near_z = '0;
			in_set = 1'b1;
		end
		cx = project_row(row_x, x, y, z);
		cy = project_row(row_y, x, y, z);
		w = project_row(row_w, x, y, z);
		if (w > W_EPS && cx >= -w && cx <= w && cy >= -w && cy <= w) begin
			nx = cx + w;
			ny = w - cy;
			while (w >= W_CAP) begin
				w = w >>> 1;
				nx = nx >>> 1;
				ny = ny >>> 1;
			end
			dx = to_pixel(nx, w, vp_w) - longint'(tgt_x);
			dy = to_pixel(ny, w, vp_h) - longint'(tgt_y);
			dsq = dx * dx + dy * dy;
			if (dsq < nearest_sq) begin
				nearest_sq = dsq;
				near_x = vx;
				near_y = vy;
				near_z = vz;
				near_hit = 1'b1;
			end
		end
		if (fin) begin
			res.hit = near_hit;
			res.px = near_hit ? near_x : 16'd0;
			res.py = near_hit ? near_y : 16'd0;
			res.pz = near_hit ? near_z : 16'd0;
			expected_picks = {expected_picks, res};
			in_set = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pick_t want;
		if (!arst_n) begin
			row_x <= '0;
			row_y <= '0;
			row_w <= '0;
			vp_w <= 13'd1;
			vp_h <= 13'd1;
			tgt_x <= '0;
			tgt_y <= '0;
			radius <= '0;
			in_set = 1'b0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				track_vertex(vertex_x, vertex_y, vertex_z, last_vertex);
			if (out_valid && out_ready) begin
				if (expected_picks.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat: found=%0b x=%h y=%h z=%h",
							found, best_x, best_y, best_z);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_picks.pop_front();
					if (found !== want.hit || best_x !== want.px || best_y !== want.py ||
							best_z !== want.pz) begin
						if (fail_count < 10)
							$display("pick mismatch: expected %0b %h %h %h, got %0b %h %h %h",
								want.hit, want.px, want.py, want.pz,
								found, best_x, best_y, best_z);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_picks.size();
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_CLIP_X:   row_x <= cfg_data;
					CFG_CLIP_Y:   row_y <= cfg_data;
					CFG_CLIP_W:   row_w <= cfg_data;
					CFG_VP_W:     vp_w <= cfg_data[12:0];
					CFG_VP_H:     vp_h <= cfg_data[12:0];
					CFG_TARGET_X: tgt_x <= cfg_data[15:0];
					CFG_TARGET_Y: tgt_y <= cfg_data[15:0];
					CFG_RADIUS:   radius <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

endmodule

### test/testbench.sv
module testbench;
	import npvp_pkg::*;

	localparam int SETTLE_CYCLES = 30;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] vertex_x = '0;
	logic [15:0] vertex_y = '0;
	logic [15:0] vertex_z = '0;
	logic        last_vertex = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        found;
	logic [15:0] best_x, best_y, best_z;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	int          fail_count;
	int          pending;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          spread;

	always #6 clk = ~clk;

	nearest_projected_vertex_pick uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.last_vertex(last_vertex),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .best_x(best_x), .best_y(best_y), .best_z(best_z),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	npvp_checker picks (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.last_vertex(last_vertex),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .best_x(best_x), .best_y(best_y), .best_z(best_z),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		vertex_x <= x;
		vertex_y <= y;
		vertex_z <= z;
		last_vertex <= fin;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || picks.expected_picks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(logic [63:0] rx, logic [63:0] ry, logic [63:0] rw,
			logic [12:0] w, logic [12:0] h, logic [15:0] tx, logic [15:0] ty,
			logic [15:0] rad);
		logic [63:0] vals[8];
		vals = '{rx, ry, rw, 64'(w), 64'(h), 64'(tx), 64'(ty), 64'(rad)};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 4'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] coord();
		if ($urandom_range(9) == 0)
			return 16'($urandom);
		return 16'($signed($urandom_range(2 * spread)) - spread);
	endfunction

	function automatic logic [15:0] coef(int lo, int hi);
		logic [15:0] c;
		c = 16'($urandom_range(hi, lo));
		return $urandom_range(1) ? c : -c;
	endfunction

	function automatic logic [63:0] friendly_row(int axis);
		logic [63:0] r;
		r = {coef(0, 255), coef(0, 200), coef(0, 200), coef(0, 200)};
		r[16 * axis +: 16] = coef(2048, 8191);
		return r;
	endfunction

	task automatic random_phase(int items, int mode);
		logic [12:0] w, h;
		logic [63:0] rw;
		int left;
		case (mode % 4)
			0: begin w = 13'd1; h = 13'd1; end
			1: begin w = 13'd4096; h = 13'd4096; end
			2: begin w = 13'd0; h = 13'd8191; end
			default: begin w = 13'($urandom_range(4096, 1)); h = 13'($urandom_range(4096, 1)); end
		endcase
		rw = {16'($urandom_range(8191, 256)), coef(0, 64), coef(0, 64), coef(0, 64)};
		spread = $urandom_range(512, 16);
		if (mode == 5)
			program_regs(64'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, w, h,
				16'hFFFF, 16'hFFFF, 16'hFFFF);
		else
			program_regs({$urandom, $urandom} & {4{16'h0}} | friendly_row(0), friendly_row(1),
				rw, w, h, 16'($urandom_range(w * 16)), 16'($urandom_range(h * 16)),
				(mode == 1) ? 16'hFFFF : 16'($urandom_range(w * 16 + h * 16)));
		left = items;
		while (left > 0) begin
			int n;
			n = $urandom_range(8, 1);
			if (n > left)
				n = left;
			for (int i = 0; i < n; i++)
				send_vertex(coord(), coord(), coord(), i == n - 1);
			left -= n;
		end
		settle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Clip x and y stay zero and w follows z, so survivors land on one pixel.
		program_regs(64'h0, 64'h0, 64'h0000_0001_0000_0000, 13'd4096, 13'd1,
			16'd32768, 16'd8, 16'd1);
		send_vertex(16'd5, 16'd0, 16'd104, 1'b0);
		send_vertex(16'd5, 16'd1, 16'd105, 1'b0);
		send_vertex(16'd7, 16'd2, 16'd105, 1'b0);
		send_vertex(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
		send_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
		send_vertex(16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
		send_vertex(16'h0000, 16'h0000, 16'h0069, 1'b1);
		settle();
		// Clip x equals w exactly: the vertex sits on the frustum edge.
		program_regs(64'h0000_0001_0000_0000, 64'h0000_FFFF_0000_0000,
			64'h0000_0001_0000_0000, 13'd8191, 13'd0, 16'd65535, 16'd0, 16'd65535);
		send_vertex(16'h1234, 16'h4321, 16'd200, 1'b0);
		send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
		send_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1);
		settle();
		// A zero radius admits nothing.
		program_regs(64'h0000_0001_0000_0000, 64'h0, 64'h0000_0001_0000_0000,
			13'd100, 13'd100, 16'd1600, 16'd800, 16'd0);
		send_vertex(16'h0000, 16'h0000, 16'd300, 1'b0);
		send_vertex(16'h0001, 16'h0000, 16'd300, 1'b1);
		settle();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 76; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 76; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			random_phase(108, ph % 6);
		end

		if (fail_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#12000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
